// File: sv/hblm_pkg.sv
// ----------------------------------------------------------------------------
// hblm_pkg
// Types and constants shared by the heartbeat link monitor modules.
// ----------------------------------------------------------------------------
package hblm_pkg;

  // field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned TIMEOUT_W  = 8;
  localparam int unsigned INTERVAL_W = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PING_TIMEOUT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_INTERVAL = 1'b1;

  // item kinds
  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // reset values
  localparam logic [TIMEOUT_W-1:0]  PING_TIMEOUT_RST    = 8'd3;
  localparam logic [INTERVAL_W-1:0] STATUS_INTERVAL_RST = 16'd30;
  localparam logic [SEQ_W-1:0]      REPLY_SEQ_RST       = 32'h7FFF_FFFF;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] now_seconds;
    logic [SEQ_W-1:0]  reply_seq;
    logic              side_active;
  } hblm_item_t;

  typedef struct packed {
    logic             link_up;
    logic             alarm_clear;
    logic             alarm_set;
    logic             send_status;
    logic             send_state_data;
    logic             send_ping;
    logic [SEQ_W-1:0] ping_seq;
    logic             drop_remote_tables;
    logic             close_message_handle;
  } hblm_result_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0]  ping_timeout_secs;
    logic [INTERVAL_W-1:0] status_interval_secs;
  } hblm_cfg_t;

endpackage

// File: sv/hblm_if.sv
// ----------------------------------------------------------------------------
// hblm_if
// Valid/ready channels of the heartbeat link monitor: input items and results.
// ----------------------------------------------------------------------------
interface hblm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] now_seconds;
  logic [31:0] reply_seq;
  logic        side_active;

  modport source (output valid, kind, now_seconds, reply_seq, side_active,
                  input ready);
  modport sink   (input valid, kind, now_seconds, reply_seq, side_active,
                  output ready);
endinterface

interface hblm_out_if;
  logic        valid;
  logic        ready;
  logic        link_up;
  logic        alarm_clear;
  logic        alarm_set;
  logic        send_status;
  logic        send_state_data;
  logic        send_ping;
  logic [31:0] ping_seq;
  logic        drop_remote_tables;
  logic        close_message_handle;

  modport source (output valid, link_up, alarm_clear, alarm_set, send_status,
                         send_state_data, send_ping, ping_seq,
                         drop_remote_tables, close_message_handle,
                  input ready);
  modport sink   (input valid, link_up, alarm_clear, alarm_set, send_status,
                        send_state_data, send_ping, ping_seq,
                        drop_remote_tables, close_message_handle,
                  output ready);
endinterface

// File: sv/hblm_cfg_regs.sv
// ----------------------------------------------------------------------------
// hblm_cfg_regs
// Configuration registers: ping timeout and status interval, write only.
// ----------------------------------------------------------------------------
module hblm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hblm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [hblm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output hblm_pkg::hblm_cfg_t              cfg
);

  hblm_pkg::hblm_cfg_t cfg_r;
  hblm_pkg::hblm_cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        hblm_pkg::REG_PING_TIMEOUT: begin
          cfg_nxt.ping_timeout_secs = cfg_wdata[hblm_pkg::TIMEOUT_W-1:0];
        end
        hblm_pkg::REG_STATUS_INTERVAL: begin
          cfg_nxt.status_interval_secs = cfg_wdata[hblm_pkg::INTERVAL_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ping_timeout_secs    <= hblm_pkg::PING_TIMEOUT_RST;
      cfg_r.status_interval_secs <= hblm_pkg::STATUS_INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/hblm_core.sv
// ----------------------------------------------------------------------------
// hblm_core
// Link state registers and the single-pass check/reply evaluation.
// ----------------------------------------------------------------------------
module hblm_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  hblm_pkg::hblm_item_t   item,
  input  hblm_pkg::hblm_cfg_t    cfg,
  output hblm_pkg::hblm_result_t result
);

  logic                        link_is_up_r,       link_is_up_nxt;
  logic                        link_was_up_r,      link_was_up_nxt;
  logic [hblm_pkg::SEQ_W-1:0]  last_ping_seq_r,    last_ping_seq_nxt;
  logic [hblm_pkg::SEQ_W-1:0]  last_reply_seq_r,   last_reply_seq_nxt;
  logic [hblm_pkg::TIME_W-1:0] ping_sent_time_r,   ping_sent_time_nxt;
  logic [hblm_pkg::TIME_W-1:0] status_sent_time_r, status_sent_time_nxt;

  logic                        is_check;
  logic                        seq_match;
  logic                        come_up;
  logic                        up_mid;
  logic [hblm_pkg::TIME_W-1:0] ping_elapsed;
  logic                        ping_due;
  logic                        lost;
  logic                        up_end;
  logic [hblm_pkg::TIME_W-1:0] status_base;
  logic [hblm_pkg::TIME_W-1:0] status_elapsed;
  logic                        status_due;
  logic [hblm_pkg::SEQ_W-1:0]  ping_seq_inc;

  // link recovery when the last ping has been answered
  assign is_check  = (item.kind == hblm_pkg::KIND_CHECK);
  assign seq_match = (last_ping_seq_r == last_reply_seq_r);
  assign come_up   = !link_was_up_r && seq_match;
  assign up_mid    = come_up || link_is_up_r;

  // ping timeout, wrapping time difference
  assign ping_elapsed = item.now_seconds - ping_sent_time_r;
  assign ping_due     = ping_elapsed >= {{(hblm_pkg::TIME_W-hblm_pkg::TIMEOUT_W){1'b0}},
                                         cfg.ping_timeout_secs};
  assign lost         = ping_due && !seq_match && up_mid;
  assign up_end       = up_mid && !lost;
  assign ping_seq_inc = last_ping_seq_r + 1'b1;

  // periodic status, measured from the possibly refreshed send time
  assign status_base    = come_up ? item.now_seconds : status_sent_time_r;
  assign status_elapsed = item.now_seconds - status_base;
  assign status_due     = status_elapsed >= {{(hblm_pkg::TIME_W-hblm_pkg::INTERVAL_W){1'b0}},
                                             cfg.status_interval_secs};

  // next state
  always_comb begin
    link_is_up_nxt       = link_is_up_r;
    link_was_up_nxt      = link_was_up_r;
    last_ping_seq_nxt    = last_ping_seq_r;
    last_reply_seq_nxt   = last_reply_seq_r;
    ping_sent_time_nxt   = ping_sent_time_r;
    status_sent_time_nxt = status_sent_time_r;
    if (step_en) begin
      if (is_check) begin
        link_is_up_nxt  = up_end;
        link_was_up_nxt = up_end;
        if (ping_due) begin
          last_ping_seq_nxt  = ping_seq_inc;
          ping_sent_time_nxt = item.now_seconds;
        end
        if (come_up || status_due) begin
          status_sent_time_nxt = item.now_seconds;
        end
      end else begin
        last_reply_seq_nxt = item.reply_seq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_is_up_r       <= 1'b0;
      link_was_up_r      <= 1'b0;
      last_ping_seq_r    <= '0;
      last_reply_seq_r   <= hblm_pkg::REPLY_SEQ_RST;
      ping_sent_time_r   <= '0;
      status_sent_time_r <= '0;
    end else begin
      link_is_up_r       <= link_is_up_nxt;
      link_was_up_r      <= link_was_up_nxt;
      last_ping_seq_r    <= last_ping_seq_nxt;
      last_reply_seq_r   <= last_reply_seq_nxt;
      ping_sent_time_r   <= ping_sent_time_nxt;
      status_sent_time_r <= status_sent_time_nxt;
    end
  end

  // result of this beat; a reply beat only reports the link state
  always_comb begin
    result = '0;
    if (is_check) begin
      result.link_up              = up_end;
      result.alarm_clear          = come_up;
      result.alarm_set            = lost;
      result.send_status          = come_up || (status_due && up_end);
      result.send_state_data      = come_up && item.side_active;
      result.send_ping            = ping_due;
      result.ping_seq             = ping_due ? ping_seq_inc : '0;
      result.drop_remote_tables   = lost;
      result.close_message_handle = ping_due && !up_end;
    end else begin
      result.link_up = link_is_up_r;
    end
  end

endmodule

// File: sv/heartbeat_link_monitor.sv
// ----------------------------------------------------------------------------
// heartbeat_link_monitor
// Pipeline: the accepting edge fills the input register; once the result
// register is free, the evaluated result moves into the result register.
// Throughput: one item per cycle while out_if.ready is high; the input
// register refills whenever the result register empties or moves on in the
// same cycle. Reset: rst_n synchronous, active low; link down, sequence and
// time state and registers return to defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
module heartbeat_link_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  hblm_in_if.sink                         in_if,
  hblm_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [hblm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hblm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  hblm_pkg::hblm_cfg_t    cfg;
  hblm_pkg::hblm_item_t   item_r;
  hblm_pkg::hblm_item_t   item_nxt;
  hblm_pkg::hblm_result_t res_r;
  hblm_pkg::hblm_result_t res_nxt;
  hblm_pkg::hblm_result_t core_res;

  logic item_vld_r, item_vld_nxt;
  logic res_vld_r,  res_vld_nxt;
  logic in_fire;
  logic step_en;
  logic res_free;

  // configuration registers
  hblm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // pipeline handshake
  assign res_free     = !res_vld_r || out_if.ready;
  assign step_en      = item_vld_r && res_free;
  assign in_if.ready  = !item_vld_r || step_en;
  assign in_fire      = in_if.valid && in_if.ready;

  // input register
  always_comb begin
    item_vld_nxt = item_vld_r;
    item_nxt     = item_r;
    if (in_fire) begin
      item_vld_nxt         = 1'b1;
      item_nxt.kind        = in_if.kind;
      item_nxt.now_seconds = in_if.now_seconds;
      item_nxt.reply_seq   = in_if.reply_seq;
      item_nxt.side_active = in_if.side_active;
    end else if (step_en) begin
      item_vld_nxt = 1'b0;
    end
  end

  // evaluation and state
  hblm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .result  (core_res)
  );

  // result register
  always_comb begin
    res_vld_nxt = res_vld_r;
    res_nxt     = res_r;
    if (step_en) begin
      res_vld_nxt = 1'b1;
      res_nxt     = core_res;
    end else if (out_if.ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  // result channel
  assign out_if.valid                = res_vld_r;
  assign out_if.link_up              = res_r.link_up;
  assign out_if.alarm_clear          = res_r.alarm_clear;
  assign out_if.alarm_set            = res_r.alarm_set;
  assign out_if.send_status          = res_r.send_status;
  assign out_if.send_state_data      = res_r.send_state_data;
  assign out_if.send_ping            = res_r.send_ping;
  assign out_if.ping_seq             = res_r.ping_seq;
  assign out_if.drop_remote_tables   = res_r.drop_remote_tables;
  assign out_if.close_message_handle = res_r.close_message_handle;

endmodule

// File: sv/hblm_checker.sv
// ----------------------------------------------------------------------------
// hblm_checker
// Port-level checks on the result channel of the heartbeat link monitor.
// ----------------------------------------------------------------------------
module hblm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_link_up,
  input logic        out_alarm_clear,
  input logic        out_alarm_set,
  input logic        out_send_status,
  input logic        out_send_ping,
  input logic [31:0] out_ping_seq,
  input logic        out_drop_remote_tables,
  input logic        out_close_message_handle
);

  // a link drop lowers the link and drops the peer tables in the same beat
  a_drop_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_set |->
      !out_link_up && out_drop_remote_tables && !out_alarm_clear)
    else $error("alarm set without link down and table drop");

  // recovery always sends status and leaves the link up
  a_up_sends_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_clear |-> out_send_status && out_link_up)
    else $error("alarm clear without status or link up");

  // sequence number only carried by a ping
  a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_ping |-> out_ping_seq == 32'd0)
    else $error("ping sequence non-zero without ping");

  // handle release only with a ping while down
  a_close_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_close_message_handle |-> out_send_ping && !out_link_up)
    else $error("handle release without ping while link down");

  // a stalled result beat holds its valid, link state and ping sequence
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ping_seq)
      && $stable(out_link_up))
    else $error("result beat changed while stalled");

endmodule

bind heartbeat_link_monitor hblm_checker u_hblm_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .out_valid                (out_if.valid),
  .out_ready                (out_if.ready),
  .out_link_up              (out_if.link_up),
  .out_alarm_clear          (out_if.alarm_clear),
  .out_alarm_set            (out_if.alarm_set),
  .out_send_status          (out_if.send_status),
  .out_send_ping            (out_if.send_ping),
  .out_ping_seq             (out_if.ping_seq),
  .out_drop_remote_tables   (out_if.drop_remote_tables),
  .out_close_message_handle (out_if.close_message_handle)
);
